[design/b64sc_pkg.sv]
// Shared types, constants and character mapping functions for the Base64 stream codec.
package b64sc_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IndexWidth = $clog2(MaxResults);

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharSlash  = 8'h2F;
   localparam logic [7:0] CharPad    = 8'h3D;

   localparam logic [5:0] LowerBase = 6'd26;
   localparam logic [5:0] DigitBase = 6'd52;
   localparam logic [5:0] PlusValue = 6'd62;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [1:0] group_position;
      logic [5:0] leftover_bits;
      logic [1:0] pad_count;
      logic       error_seen;
   } stream_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_message;
      logic       error;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MaxResults-1:0] items;
      logic [CountWidth-1:0]         count;
      stream_state_type              next_state;
   } step_result_type;

   typedef struct packed {
      logic       is_pad;
      logic       is_bad;
      logic [5:0] value;
   } symbol_type;

   function automatic logic [7:0] to_char(input logic [5:0] v);
      logic [7:0] ext;
      ext = {2'b00, v};
      if (v < LowerBase) begin
         return CharUpperA + ext;
      end else if (v < DigitBase) begin
         return CharLowerA + ext - {2'b00, LowerBase};
      end else if (v < PlusValue) begin
         return CharZero + ext - {2'b00, DigitBase};
      end else if (v == PlusValue) begin
         return CharPlus;
      end
      return CharSlash;
   endfunction

   function automatic symbol_type from_char(input logic [7:0] c);
      symbol_type s;
      s = '0;
      if (c inside {[CharUpperA:CharUpperZ]}) begin
         s.value = 6'(c - CharUpperA);
      end else if (c inside {[CharLowerA:CharLowerZ]}) begin
         s.value = 6'(c - CharLowerA + {2'b00, LowerBase});
      end else if (c inside {[CharZero:CharNine]}) begin
         s.value = 6'(c - CharZero + {2'b00, DigitBase});
      end else if (c == CharPlus) begin
         s.value = PlusValue;
      end else if (c == CharSlash) begin
         s.value = 6'd63;
      end else if (c == CharPad) begin
         s.is_pad = 1'b1;
      end else begin
         s.is_bad = 1'b1;
      end
      return s;
   endfunction

endpackage

[design/b64sc_step.sv]
// Combinational encode/decode of one item against the stream state.
module b64sc_step (
   input  b64sc_pkg::mode_type         mode,
   input  logic [7:0]                  data_byte,
   input  logic                        last,
   input  b64sc_pkg::stream_state_type cur_state,
   output b64sc_pkg::step_result_type  result
);
   import b64sc_pkg::*;

   always_comb begin
      step_result_type  res;
      stream_state_type st;
      symbol_type       sym;
      logic [CountWidth-1:0] n;
      logic [IndexWidth-1:0] idx;
      logic [7:0]       byte_out;
      logic             have;
      logic             bad;
      logic             pad;
      logic [5:0]       v;

      res      = '0;
      st       = cur_state;
      sym      = from_char(data_byte);
      n        = '0;
      idx      = '0;
      byte_out = '0;
      have     = 1'b0;
      bad      = 1'b0;
      pad      = 1'b0;
      v        = '0;

      if (mode == MODE_ENCODE) begin
         case (cur_state.group_position)
            2'd1: begin
               res.items[0].out_byte = to_char({cur_state.leftover_bits[1:0], data_byte[7:4]});
               st.leftover_bits = {2'b00, data_byte[3:0]};
               st.group_position = 2'd2;
               n = CountWidth'(1);
            end
            2'd2: begin
               res.items[0].out_byte = to_char({cur_state.leftover_bits[3:0], data_byte[7:6]});
               res.items[1].out_byte = to_char(data_byte[5:0]);
               st.leftover_bits = '0;
               st.group_position = 2'd0;
               n = CountWidth'(2);
            end
            default: begin
               res.items[0].out_byte = to_char(data_byte[7:2]);
               st.leftover_bits = {4'b0000, data_byte[1:0]};
               st.group_position = 2'd1;
               n = CountWidth'(1);
            end
         endcase
         // flush the partial group and pad out to four characters
         if (last) begin
            idx = n[IndexWidth-1:0];
            if (st.group_position == 2'd1) begin
               res.items[idx].out_byte = to_char({st.leftover_bits[1:0], 4'b0000});
               res.items[idx + IndexWidth'(1)].out_byte = CharPad;
               res.items[idx + IndexWidth'(2)].out_byte = CharPad;
               n = n + CountWidth'(3);
            end else if (st.group_position == 2'd2) begin
               res.items[idx].out_byte = to_char({st.leftover_bits[3:0], 2'b00});
               res.items[idx + IndexWidth'(1)].out_byte = CharPad;
               n = n + CountWidth'(2);
            end
         end
         for (int i = 0; i < MaxResults; i++) begin
            res.items[i].byte_valid = 1'b1;
            res.items[i].error = cur_state.error_seen;
         end
         if (last) begin
            res.items[IndexWidth'(n - CountWidth'(1))].end_of_message = 1'b1;
         end
      end else begin
         // a pad in the first half of a group is as bad as a foreign character
         bad = sym.is_bad || (sym.is_pad && (cur_state.group_position < 2'd2));
         pad = sym.is_pad && !bad;
         v   = bad ? 6'd0 : sym.value;
         if (bad) begin
            st.error_seen = 1'b1;
         end
         if (pad) begin
            if (cur_state.pad_count != 2'd3) begin
               st.pad_count = cur_state.pad_count + 2'd1;
            end
         end else if (cur_state.pad_count != 2'd0) begin
            st.error_seen = 1'b1;
         end else begin
            case (cur_state.group_position)
               2'd0: begin
                  st.leftover_bits = v;
               end
               2'd1: begin
                  byte_out = {cur_state.leftover_bits, v[5:4]};
                  st.leftover_bits = {2'b00, v[3:0]};
                  have = 1'b1;
               end
               2'd2: begin
                  byte_out = {cur_state.leftover_bits[3:0], v[5:2]};
                  st.leftover_bits = {4'b0000, v[1:0]};
                  have = 1'b1;
               end
               default: begin
                  byte_out = {cur_state.leftover_bits[1:0], v};
                  st.leftover_bits = '0;
                  have = 1'b1;
               end
            endcase
         end
         st.group_position = cur_state.group_position + 2'd1;
         if (last && (st.group_position != 2'd0)) begin
            st.error_seen = 1'b1;
         end
         if (have || last) begin
            res.items[0].out_byte = byte_out;
            res.items[0].byte_valid = have;
            res.items[0].end_of_message = last;
            res.items[0].error = st.error_seen;
            n = CountWidth'(1);
         end
      end

      res.count = n;
      res.next_state = last ? '0 : st;
      result = res;
   end

endmodule

[design/base64_stream_codec.sv]
// Top level of the streaming Base64 codec: input register, step logic, result buffer.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data_byte, req_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_out_byte, rsp_byte_valid,
//          |           |                     | rsp_end_of_message, rsp_error
//  csr     | in        | csr_valid/csr_ready | csr_mode
//
// An item waits in the input register until the result buffer is free, then its results
// (zero to four) are written at once into the result buffer and leave one per cycle
// while rsp_stall is low. Throughput is set by the single result port, so an encoded
// byte yields one or two results mid-stream and up to four on the last byte.
// Reset is synchronous and clears mode to encode and the stream state.
// A stalled result holds the buffer; the input register takes one more item meanwhile.
// csr_ready is high only while both the input register and the result buffer are empty.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_message,
   output logic       rsp_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_mode
);
   import b64sc_pkg::*;

   mode_type              mode_ff;
   stream_state_type      state_ff;
   logic                  in_full_ff, in_full_in;
   logic [7:0]            in_data_ff;
   logic                  in_last_ff;
   rsp_item_type          items_ff [MaxResults];
   logic [CountWidth-1:0] cnt_ff;
   logic [IndexWidth-1:0] rd_ff;
   step_result_type       step;
   logic                  pop, buf_free, load, accept, csr_write;

   b64sc_step u_step (
      .mode      (mode_ff),
      .data_byte (in_data_ff),
      .last      (in_last_ff),
      .cur_state (state_ff),
      .result    (step)
   );

   assign pop       = (cnt_ff != '0) && !rsp_stall;
   assign buf_free  = (cnt_ff == '0) || ((cnt_ff == CountWidth'(1)) && pop);
   assign load      = in_full_ff && buf_free;
   assign req_stall = in_full_ff && !buf_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !in_full_ff && (cnt_ff == '0);
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      in_full_in = in_full_ff;
      if (accept) begin
         in_full_in = 1'b1;
      end else if (load) begin
         in_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ENCODE;
         state_ff   <= '0;
         in_full_ff <= 1'b0;
         cnt_ff     <= '0;
         rd_ff      <= '0;
      end else begin
         in_full_ff <= in_full_in;
         if (csr_write) begin
            mode_ff  <= mode_type'(csr_mode);
            state_ff <= '0;
         end else if (load) begin
            state_ff <= step.next_state;
         end
         if (load) begin
            cnt_ff <= step.count;
            rd_ff  <= '0;
         end else if (pop) begin
            cnt_ff <= cnt_ff - CountWidth'(1);
            rd_ff  <= rd_ff + IndexWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (load) begin
         for (int i = 0; i < MaxResults; i++) begin
            items_ff[i] <= step.items[i];
         end
      end
   end

   assign rsp_valid          = (cnt_ff != '0);
   assign rsp_out_byte       = items_ff[rd_ff].out_byte;
   assign rsp_byte_valid     = items_ff[rd_ff].byte_valid;
   assign rsp_end_of_message = items_ff[rd_ff].end_of_message;
   assign rsp_error          = items_ff[rd_ff].error;

   // buffer read position plus remaining results never runs past the buffer
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rd_ff} + cnt_ff) <= CountWidth'(MaxResults))
      else $error("result buffer overrun");

   // the stream state is back to zero after a message end is processed
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (load && in_last_ff && !csr_write) |=> (state_ff == '0))
      else $error("stream state not cleared at message end");

   // encoded characters never carry the error flag
   a_enc_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mode_ff == MODE_ENCODE)) |-> !rsp_error)
      else $error("error flag on encode result");

   // a result without data is only ever the end marker
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_end_of_message)
      else $error("empty result that is not an end marker");

endmodule

[tb/base64_stream_codec_checker.sv]
// Result checker for the Base64 stream codec: tracks codec state and compares each result.
module base64_stream_codec_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_end_of_message,
   input  logic       rsp_error,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_mode,
   output int         expected_left,
   output int         mismatch_count
);
   import b64sc_pkg::*;

   mode_type     codec_mode;
   logic [1:0]   slot;
   logic [5:0]   carry_bits;
   logic [1:0]   pads_seen;
   logic         err_flag;
   rsp_item_type pending_results[$];
   rsp_item_type seen;
   rsp_item_type want;
   int           fails;

   initial begin
      fails = 0;
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < LowerBase) return CharUpperA + 8'(v);
      if (v < DigitBase) return CharLowerA + 8'(v - LowerBase);
      if (v < PlusValue) return CharZero + 8'(v - DigitBase);
      if (v == PlusValue) return CharPlus;
      return CharSlash;
   endfunction

   function automatic symbol_type char_sextet(input logic [7:0] c);
      symbol_type s;
      s = '0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         s.value = 6'(c - CharUpperA);
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         s.value = 6'(c - CharLowerA) + LowerBase;
      end else if (c >= CharZero && c <= CharNine) begin
         s.value = 6'(c - CharZero) + DigitBase;
      end else if (c == CharPlus) begin
         s.value = PlusValue;
      end else if (c == CharSlash) begin
         s.value = 6'd63;
      end else if (c == CharPad) begin
         s.is_pad = 1'b1;
      end else begin
         s.is_bad = 1'b1;
      end
      return s;
   endfunction

   task automatic clear_stream();
      slot       = '0;
      carry_bits = '0;
      pads_seen  = '0;
      err_flag   = 1'b0;
   endtask

   task automatic push_result(input logic [7:0] b, input logic bv, input logic eom);
      rsp_item_type r;
      r.out_byte       = b;
      r.byte_valid     = bv;
      r.end_of_message = eom;
      r.error          = err_flag;
      pending_results.push_back(r);
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] chars[$];
      int         k;
      case (slot)
         2'd1: begin
            chars.push_back(sextet_char({carry_bits[1:0], b[7:4]}));
            carry_bits = {2'b00, b[3:0]};
            slot       = 2'd2;
         end
         2'd2: begin
            chars.push_back(sextet_char({carry_bits[3:0], b[7:6]}));
            chars.push_back(sextet_char(b[5:0]));
            carry_bits = '0;
            slot       = 2'd0;
         end
         default: begin
            chars.push_back(sextet_char(b[7:2]));
            carry_bits = {4'b0000, b[1:0]};
            slot       = 2'd1;
         end
      endcase
      if (fin) begin
         // flush the partial group, then pad out to four characters
         if (slot == 2'd1) begin
            chars.push_back(sextet_char({carry_bits[1:0], 4'b0000}));
            chars.push_back(CharPad);
            chars.push_back(CharPad);
         end else if (slot == 2'd2) begin
            chars.push_back(sextet_char({carry_bits[3:0], 2'b00}));
            chars.push_back(CharPad);
         end
      end
      for (k = 0; k < chars.size(); k++)
         push_result(chars[k], 1'b1, fin && (k == chars.size() - 1));
      if (fin) clear_stream();
   endtask

   task automatic decode_char(input logic [7:0] c, input logic fin);
      symbol_type s;
      logic       have;
      logic [7:0] data;
      s    = char_sextet(c);
      have = 1'b0;
      data = '0;
      // a pad in the first half of a group is just a bad character
      if (s.is_pad && slot < 2'd2) begin
         s.is_pad = 1'b0;
         s.is_bad = 1'b1;
      end
      if (s.is_bad) begin
         err_flag = 1'b1;
         s.value  = '0;
      end
      if (s.is_pad) begin
         if (pads_seen != 2'd3) pads_seen = pads_seen + 2'd1;
      end else if (pads_seen != 2'd0) begin
         err_flag = 1'b1;
      end else begin
         case (slot)
            2'd0: carry_bits = s.value;
            2'd1: begin
               data       = {carry_bits, s.value[5:4]};
               carry_bits = {2'b00, s.value[3:0]};
               have       = 1'b1;
            end
            2'd2: begin
               data       = {carry_bits[3:0], s.value[5:2]};
               carry_bits = {4'b0000, s.value[1:0]};
               have       = 1'b1;
            end
            default: begin
               data       = {carry_bits[1:0], s.value};
               carry_bits = '0;
               have       = 1'b1;
            end
         endcase
      end
      slot = slot + 2'd1;
      if (fin && slot != 2'd0) err_flag = 1'b1;
      if (have) push_result(data, 1'b1, fin);
      else if (fin) push_result(8'h00, 1'b0, 1'b1);
      if (fin) clear_stream();
   endtask

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: rsp %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         codec_mode = MODE_ENCODE;
         clear_stream();
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            codec_mode = mode_type'(csr_mode);
            clear_stream();
         end
         if (req_valid && !req_stall) begin
            if (codec_mode == MODE_DECODE) decode_char(req_data_byte, req_last);
            else encode_byte(req_data_byte, req_last);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_out_byte, rsp_byte_valid, rsp_end_of_message, rsp_error};
            if (pending_results.size() == 0) begin
               $display("%0t: result %0h arrived with no transaction pending, expected none",
                        $time, seen);
               fails++;
            end else begin
               want = pending_results.pop_front();
               compare_field("out_byte", want.out_byte, seen.out_byte);
               compare_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
               compare_field("end_of_message", 8'(want.end_of_message),
                             8'(seen.end_of_message));
               compare_field("error", 8'(want.error), 8'(seen.error));
            end
         end
      end
      expected_left  <= pending_results.size();
      mismatch_count <= fails;
   end

endmodule

[tb/base64_stream_codec_test.sv]
// Top of the Base64 stream codec testbench: clock, reset, stimulus, pacing and verdict.
module base64_stream_codec_test;
   import b64sc_pkg::*;

   localparam int QuietLimit = 1000;
   localparam int SettleCycles = 6;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_message;
   logic       rsp_error;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_mode;

   int         expected_left;
   int         mismatch_count;
   int         quiet_cycles;
   bit         gaps_on;
   bit         stall_on;
   string      b64_alphabet;

   base64_stream_codec u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_error          (rsp_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_mode           (csr_mode)
   );

   base64_stream_codec_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_error          (rsp_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_mode           (csr_mode),
      .expected_left      (expected_left),
      .mismatch_count     (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls in random bursts
   initial begin
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAIL base64_stream_codec");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] data, input logic fin);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last      <= fin;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_string(input string s);
      int k;
      for (k = 0; k < s.len(); k++) send_item(s[k], k == s.len() - 1);
   endtask

   task automatic send_queue(input logic [7:0] text[$]);
      int k;
      for (k = 0; k < text.size(); k++) send_item(text[k], k == text.size() - 1);
   endtask

   // hold off until every expected result is out and the pipeline has emptied
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      drain();
      csr_valid <= 1'b1;
      csr_mode  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      return b64_alphabet[$urandom_range(0, 63)];
   endfunction

   task automatic send_encode_message(output int count);
      logic [7:0] text[$];
      int         k;
      int         len;
      len = $urandom_range(1, 9);
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 7))
            0:       text.push_back(8'h00);
            1:       text.push_back(8'hFF);
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      send_queue(text);
      count = len;
   endtask

   task automatic send_decode_message(output int count);
      logic [7:0] text[$];
      int         k;
      int         groups;
      int         pads;
      int         flavor;
      int         spot;
      flavor = $urandom_range(0, 9);
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      for (k = 0; k < 4 * groups; k++) text.push_back(pick_char());
      pads = $urandom_range(0, 2);
      if (pads >= 1) text[text.size() - 1] = CharPad;
      if (pads == 2) text[text.size() - 2] = CharPad;
      if (flavor >= 8) begin
         // noise: arbitrary bytes, pads and alphabet characters
         text.delete();
         groups = $urandom_range(1, 9);
         for (k = 0; k < groups; k++) begin
            case ($urandom_range(0, 3))
               0:       text.push_back(CharPad);
               1:       text.push_back(pick_char());
               default: text.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end else if (flavor == 7) begin
         spot = $urandom_range(0, text.size() - 1);
         case ($urandom_range(0, 3))
            0: text[spot] = 8'($urandom_range(0, 255));
            1: if (text.size() > 1) void'(text.pop_back());
            2: text[spot] = CharPad;
            default: text.push_back(pick_char());
         endcase
      end
      send_queue(text);
      count = text.size();
   endtask

   initial begin
      int phase;
      int sent;
      int n;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_last      <= 1'b0;
      csr_valid     <= 1'b0;
      csr_mode      <= MODE_ENCODE;
      gaps_on       = 1'b1;
      stall_on      = 1'b1;
      b64_alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed encode: one, two and three byte messages at the value extremes
      write_mode(MODE_ENCODE);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'hFB, 1'b0);
      send_item(8'hEF, 1'b0);
      send_item(8'hBE, 1'b1);

      // directed decode
      write_mode(MODE_DECODE);
      send_string("TWE=");
      send_string("TQ==");
      send_string("AB=C");
      send_item(CharPad, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item("z", 1'b0);
      send_item("9", 1'b1);
      send_string("QR==");
      send_string("A");
      // a mode write in mid-message drops the partial group
      send_item("Q", 1'b0);
      send_item("U", 1'b0);
      write_mode(MODE_DECODE);
      send_string("QUJD");

      for (phase = 0; phase < 8; phase++) begin
         gaps_on  = (phase < 7) && (phase % 3 != 2);
         stall_on = (phase < 7) && (phase % 3 != 1);
         write_mode((phase % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
         sent = 0;
         while (sent < 37) begin
            if (phase % 2 == 1) send_decode_message(n);
            else send_encode_message(n);
            sent += n;
            if (phase < 7 && $urandom_range(0, 15) == 0) drain();
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("PASS base64_stream_codec");
      end else begin
         $display("FAIL base64_stream_codec");
      end
      $finish;
   end

endmodule

[files.f]
design/b64sc_pkg.sv
design/b64sc_step.sv
design/base64_stream_codec.sv
tb/base64_stream_codec_checker.sv
tb/base64_stream_codec_test.sv
